### hdl/savt_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and state encodings for the shaft angle and velocity tracker.
package savt_pkg;

    localparam int ANGLE_BITS = 12;
    localparam int FULL_COUNTS = 1 << ANGLE_BITS;

    // (turns - ref_turns) * FULL + angle difference, exact
    localparam int DELTA_W = ANGLE_BITS + 34;
    // delta magnitudes at or above 2^40 saturate without dividing
    localparam int MAG_SAT_BIT = 40;
    localparam int NUM_W = 60;
    localparam int SCALE_W = 20;
    localparam logic [SCALE_W-1:0] VEL_SCALE = 20'd1000000;
    // elapsed time of an update is positive and below 2^31
    localparam int DIV_W = 31;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ELAPSED = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLE_PAIRS = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE = 8'd3;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [15:0]           min_elapsed_us;
        logic [6:0]            pp_count;
        logic [ANGLE_BITS-1:0] zero_offset;
        logic                  reverse_direction;
    } t_cfg;

    // one classified sample, front to back
    typedef struct packed {
        logic signed [31:0]         rotation_count;
        logic [ANGLE_BITS-1:0]      shaft_angle;
        logic [ANGLE_BITS-1:0]      electrical_angle;
        logic                       update;
        logic signed [DELTA_W-1:0]  delta;
        logic [DIV_W-1:0]           elapsed;
    } t_cmd;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] electrical_angle;
        logic signed [31:0]    velocity_cps;
        logic [ANGLE_BITS-1:0] shaft_angle;
        logic signed [31:0]    rotation_count;
        logic                  velocity_updated;
    } t_result;

    typedef enum logic [1:0] {
        F_IDLE,
        F_TRACK,
        F_DELTA,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ABS,
        B_MUL,
        B_SUM,
        B_CHECK,
        B_DIV,
        B_SIGN,
        B_OUT
    } t_back_state;

endpackage

### hdl/savt_front.sv
`timescale 1ns / 1ps
// Front end: takes samples, tracks turns and the velocity reference, classifies each sample.
module savt_front import savt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [ANGLE_BITS-1:0] i_angle,
    input  logic [31:0]           i_ts,
    input  logic                  i_full,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    t_front_state r_state, n_state;

    logic                  r_primed;
    logic [ANGLE_BITS-1:0] r_last_angle;
    logic signed [31:0]    r_turns;
    logic [ANGLE_BITS-1:0] r_ref_angle;
    logic signed [31:0]    r_ref_turns;
    logic [31:0]           r_ref_time;

    logic [ANGLE_BITS-1:0] r_in_angle;
    logic [31:0]           r_in_ts;
    logic                  r_update;
    logic [DIV_W-1:0]      r_diff;
    logic signed [32:0]    r_dturns;
    logic [ANGLE_BITS:0]   r_dangle;
    logic [ANGLE_BITS-1:0] r_elec;

    logic [ANGLE_BITS:0]   d;
    logic [ANGLE_BITS-1:0] ad;
    logic [ANGLE_BITS+2:0] ad_x5;
    logic                  wrap;
    logic signed [31:0]    turns_next;
    logic [31:0]           elapsed;
    logic [15:0]           min_eff;
    logic                  backwards;
    logic                  due;
    logic [ANGLE_BITS+6:0] prod;
    logic [ANGLE_BITS-1:0] e_dir;

    // wrap detection: 5*|d| > 4*FULL
    always_comb begin
        d = {1'b0, r_in_angle} - {1'b0, r_last_angle};
        ad = d[ANGLE_BITS] ? ANGLE_BITS'(-d) : d[ANGLE_BITS-1:0];
        ad_x5 = {3'b000, ad} + {1'b0, ad, 2'b00};
        wrap = ad_x5 > (ANGLE_BITS+3)'(4 * FULL_COUNTS);
        turns_next = r_turns;
        if (wrap) begin
            if (!d[ANGLE_BITS]) begin
                if (r_turns != S32_MIN) turns_next = r_turns - 32'sd1;
            end else begin
                if (r_turns != S32_MAX) turns_next = r_turns + 32'sd1;
            end
        end
    end

    always_comb begin
        elapsed = r_in_ts - r_ref_time;
        min_eff = (i_cfg.min_elapsed_us == 16'd0) ? 16'd1 : i_cfg.min_elapsed_us;
        backwards = elapsed[31];
        due = !backwards && (elapsed >= {16'd0, min_eff});
    end

    always_comb begin
        prod = i_cfg.pp_count * r_last_angle;
        e_dir = i_cfg.reverse_direction ? ANGLE_BITS'(-prod[ANGLE_BITS-1:0])
                                        : prod[ANGLE_BITS-1:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (i_valid) n_state = F_TRACK;
            F_TRACK: n_state = F_DELTA;
            F_DELTA: n_state = F_PUSH;
            F_PUSH:  if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == F_IDLE);
        o_push  = (r_state == F_PUSH) && !i_full;
    end

    always_comb begin
        o_cmd.rotation_count   = r_turns;
        o_cmd.shaft_angle      = r_last_angle;
        o_cmd.electrical_angle = r_elec;
        o_cmd.update           = r_update;
        o_cmd.delta = {{(DELTA_W-33-ANGLE_BITS){r_dturns[32]}}, r_dturns, {ANGLE_BITS{1'b0}}}
                    + {{(DELTA_W-ANGLE_BITS-1){r_dangle[ANGLE_BITS]}}, r_dangle};
        o_cmd.elapsed = r_diff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= F_IDLE;
            r_primed     <= 1'b0;
            r_last_angle <= '0;
            r_turns      <= '0;
            r_ref_angle  <= '0;
            r_ref_turns  <= '0;
            r_ref_time   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                F_TRACK: begin
                    r_last_angle <= r_in_angle;
                    if (!r_primed) begin
                        r_primed    <= 1'b1;
                        r_ref_angle <= r_in_angle;
                        r_ref_turns <= r_turns;
                        r_ref_time  <= r_in_ts;
                    end else begin
                        r_turns <= turns_next;
                        if (backwards) begin
                            r_ref_angle <= r_in_angle;
                            r_ref_turns <= turns_next;
                            r_ref_time  <= r_in_ts;
                        end
                    end
                end
                F_DELTA: begin
                    if (r_update) begin
                        r_ref_angle <= r_last_angle;
                        r_ref_turns <= r_turns;
                        r_ref_time  <= r_in_ts;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    r_in_angle <= i_angle;
                    r_in_ts    <= i_ts;
                end
            end
            F_TRACK: begin
                r_update <= r_primed && due;
                r_diff   <= elapsed[DIV_W-1:0];
            end
            F_DELTA: begin
                r_dturns <= {r_turns[31], r_turns} - {r_ref_turns[31], r_ref_turns};
                r_dangle <= {1'b0, r_last_angle} - {1'b0, r_ref_angle};
                r_elec   <= e_dir - i_cfg.zero_offset;
            end
            default: ;
        endcase
    end

endmodule

### hdl/savt_fifo.sv
`timescale 1ns / 1ps
// Two-entry command queue between the front end and the velocity back end.
module savt_fifo import savt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_wr_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_rd_data,
    output logic o_empty
);

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_PTR_W:0]   r_count;

    assign o_full    = (r_count == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

### hdl/savt_back.sv
`timescale 1ns / 1ps
// Back end: velocity scaling, iterative division, saturation and the output register.
module savt_back import savt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_empty,
    input  t_cmd    i_cmd,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    t_back_state r_state, n_state;

    t_cmd                 r_cmd;
    logic                 r_neg;
    logic [DELTA_W-1:0]   r_mag;
    logic                 r_big;
    logic [NUM_W-9:0]     r_plo;
    logic [NUM_W-33:0]    r_phi;
    logic [NUM_W-1:0]     r_num;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_sat;
    logic signed [31:0]   r_held;
    logic                 r_out_valid;
    t_result              r_out;

    logic                 ovf;
    logic [DIV_W:0]       trial;
    logic                 ge;
    logic                 load;
    logic                 div_last;

    always_comb begin
        // quotient reaches 2^31 exactly when num >= elapsed * 2^31
        ovf      = {2'b00, r_num} >= {r_cmd.elapsed, {DIV_W{1'b0}}};
        trial    = {r_rem, r_num[DIV_W-1]};
        ge       = trial >= {1'b0, r_cmd.elapsed};
        div_last = (r_cnt == DIV_CNT_W'(DIV_W - 1));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (!i_empty) n_state = i_cmd.update ? B_ABS : B_OUT;
            B_ABS:   n_state = B_MUL;
            B_MUL:   n_state = B_SUM;
            B_SUM:   n_state = B_CHECK;
            B_CHECK: n_state = (r_big || ovf) ? B_SIGN : B_DIV;
            B_DIV:   if (div_last) n_state = B_SIGN;
            B_SIGN:  n_state = B_OUT;
            B_OUT:   if (!r_out_valid || i_ready) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop = (r_state == B_IDLE) && !i_empty;
        load  = (r_state == B_OUT) && (!r_out_valid || i_ready);
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_SIGN) begin
                if (r_sat) r_held <= r_neg ? S32_MIN : S32_MAX;
                else if (r_neg) r_held <= -$signed({1'b0, r_quo});
                else r_held <= $signed({1'b0, r_quo});
            end
            if (load) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_cmd <= i_cmd;
        case (r_state)
            B_ABS: begin
                r_neg <= r_cmd.delta[DELTA_W-1];
                r_mag <= r_cmd.delta[DELTA_W-1] ? DELTA_W'(-r_cmd.delta) : r_cmd.delta;
            end
            B_MUL: begin
                r_plo <= r_mag[31:0] * VEL_SCALE;
                r_phi <= r_mag[MAG_SAT_BIT-1:32] * VEL_SCALE;
                r_big <= |r_mag[DELTA_W-1:MAG_SAT_BIT];
            end
            B_SUM:   r_num <= {8'd0, r_plo} + {r_phi, 32'd0};
            B_CHECK: begin
                r_sat <= r_big || ovf;
                r_rem <= {2'b00, r_num[NUM_W-1:DIV_W]};
                r_quo <= '0;
                r_cnt <= '0;
            end
            B_DIV: begin
                r_rem <= ge ? DIV_W'(trial - {1'b0, r_cmd.elapsed}) : trial[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], ge};
                r_num <= {r_num[NUM_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
            end
            default: ;
        endcase
        if (load) begin
            r_out.rotation_count   <= r_cmd.rotation_count;
            r_out.shaft_angle      <= r_cmd.shaft_angle;
            r_out.velocity_cps     <= r_held;
            r_out.velocity_updated <= r_cmd.update;
            r_out.electrical_angle <= r_cmd.electrical_angle;
        end
    end

endmodule

### hdl/shaft_angle_velocity_tracker.sv
`timescale 1ns / 1ps
// Top level: shaft angle, multi-turn count, velocity and electrical angle tracker.
//
// Input stream (s_axis): one word per sensor sample, raw angle and microsecond
// timestamp. Output stream (m_axis): one word per sample with the turn count,
// angle, velocity in counts per second and electrical angle; tuser flags a
// velocity recomputed by this sample. Config channel: index 0 minimum elapsed
// microseconds, 1 pole pairs, 2 zero offset, 3 reverse direction; other
// indexes are ignored. Write registers only while the block is idle.
// The front end takes one word at a time and accepts the next only after it
// has pushed the last one into the queue; the back end passes a sample that
// holds velocity straight to the output register and computes an update
// with the 31-step shift-subtract divider. A two-word queue sits between
// front and back end.
// Reset (synchronous, active low) clears the tracking state and restores the
// register defaults; the first sample after reset only primes the reference.
// A stalled receiver holds the output register; the queue then fills and the
// input side stops taking words.
module shaft_angle_velocity_tracker import savt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,  // sample_angle[11:0], timestamp_us[43:12], pad
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [87:0]          m_axis_tdata,  // rotation_count[31:0], shaft_angle[43:32],
                                                // velocity_cps[75:44], electrical_angle[87:76]
    output logic                 m_axis_tuser,  // velocity_updated
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    t_cfg    r_cfg;
    logic    push;
    logic    pop;
    logic    full;
    logic    empty;
    t_cmd    cmd_wr;
    t_cmd    cmd_rd;
    t_result result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_elapsed_us    <= 16'd100;
            r_cfg.pp_count          <= 7'd7;
            r_cfg.zero_offset       <= '0;
            r_cfg.reverse_direction <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MIN_ELAPSED: r_cfg.min_elapsed_us    <= i_cfg_data;
                REG_POLE_PAIRS:  r_cfg.pp_count          <= i_cfg_data[6:0];
                REG_ZERO_OFFSET: r_cfg.zero_offset       <= i_cfg_data[ANGLE_BITS-1:0];
                REG_REVERSE:     r_cfg.reverse_direction <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    savt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_angle (s_axis_tdata[ANGLE_BITS-1:0]),
        .i_ts    (s_axis_tdata[43:12]),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd_wr)
    );

    savt_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (cmd_wr),
        .o_full    (full),
        .i_pop     (pop),
        .o_rd_data (cmd_rd),
        .o_empty   (empty)
    );

    savt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_cmd    (cmd_rd),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = {result.electrical_angle, result.velocity_cps,
                           result.shaft_angle, result.rotation_count};
    assign m_axis_tuser = result.velocity_updated;

endmodule

### dv/tb_shaft_angle_velocity_tracker.sv
`timescale 1ns / 1ps
// Self-checking testbench for the shaft angle and velocity tracker.
module tb_shaft_angle_velocity_tracker;
    import savt_pkg::*;

    typedef struct {
        logic [11:0] angle;
        logic [31:0] ts;
        bit          drain_first;  // hold this word back until every reading is in
    } t_sample;

    typedef struct {
        logic [15:0] min_elapsed;
        logic [6:0]  pp_count;
        logic [11:0] zero_offset;
        logic        reverse;
    } t_settings;

    logic         i_clk;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [87:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0]  i_cfg_data = '0;

    shaft_angle_velocity_tracker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    t_sample samples_q[$];
    t_result reading_q[$];
    int      errors = 0;

    // register shadow, updated on each accepted config write
    t_settings regs = '{16'd100, 7'd7, 12'd0, 1'b0};

    // tracker state
    bit                 primed = 0;
    logic [11:0]        last_ang = '0;
    logic signed [31:0] turns = '0;
    logic [11:0]        ref_ang = '0;
    logic signed [31:0] ref_turns = '0;
    logic [31:0]        ref_ts = '0;
    logic signed [31:0] held_vel = '0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report(input string msg);
        $display("%0t ns: %s", $time, msg);
        errors++;
    endtask

    function automatic logic signed [31:0] clamp_s32(input longint v);
        if (v > longint'(S32_MAX)) return S32_MAX;
        if (v < longint'(S32_MIN)) return S32_MIN;
        return v[31:0];
    endfunction

    // advance the tracker by one sample and return the reading it gives
    function automatic t_result track_sample(input logic [11:0] angle, input logic [31:0] ts);
        t_result            r;
        longint             d;
        longint             delta;
        longint unsigned    mag;
        longint unsigned    q;
        longint             v;
        logic [31:0]        elapsed;
        logic [31:0]        minimum;
        logic [31:0]        e;
        logic               upd;
        upd = 1'b0;
        if (!primed) begin
            primed    = 1;
            last_ang  = angle;
            ref_ang   = angle;
            ref_turns = turns;
            ref_ts    = ts;
        end else begin
            d = longint'(angle) - longint'(last_ang);
            if (5 * (d < 0 ? -d : d) > 4 * FULL_COUNTS)
                turns = clamp_s32(longint'(turns) + (d > 0 ? -1 : 1));
            last_ang = angle;
            elapsed = ts - ref_ts;
            minimum = (regs.min_elapsed == 0) ? 32'd1 : 32'(regs.min_elapsed);
            if (elapsed[31]) begin
                ref_ang   = last_ang;
                ref_turns = turns;
                ref_ts    = ts;
            end else if (elapsed >= minimum) begin
                delta = (longint'(turns) - longint'(ref_turns)) * FULL_COUNTS
                      + (longint'(last_ang) - longint'(ref_ang));
                mag = (delta < 0) ? longint'(-delta) : delta;
                if (mag >= (64'd1 << MAG_SAT_BIT)) begin
                    v = (delta < 0) ? longint'(S32_MIN) - 1 : longint'(S32_MAX) + 1;
                end else begin
                    q = (mag * 64'd1000000) / longint'(elapsed);
                    if (q > (64'd1 << 33)) q = 64'd1 << 33;
                    v = (delta < 0) ? -longint'(q) : longint'(q);
                end
                held_vel  = clamp_s32(v);
                ref_ang   = last_ang;
                ref_turns = turns;
                ref_ts    = ts;
                upd       = 1'b1;
            end
        end
        e = 32'(regs.pp_count) * 32'(last_ang);
        if (regs.reverse) e = 32'd0 - e;
        e = e - 32'(regs.zero_offset);
        r.rotation_count   = turns;
        r.shaft_angle      = last_ang;
        r.velocity_cps     = held_vel;
        r.velocity_updated = upd;
        r.electrical_angle = e[11:0];
        return r;
    endfunction

    // ---------------- driver ----------------
    t_sample offered;
    int      gap_left = 0;
    int      n_sent = 0;

    always @(posedge i_clk) begin
        logic nv;
        nv = s_axis_tvalid;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                reading_q.push_back(track_sample(offered.angle, offered.ts));
                n_sent++;
                gap_left = ((n_sent / 50) % 4 == 1) ? 0 : $urandom_range(0, 11);
                nv = 1'b0;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (samples_q.size() > 0 &&
                             (!samples_q[0].drain_first || reading_q.size() == 0)) begin
                    offered = samples_q.pop_front();
                    s_axis_tdata <= {4'b0, offered.ts, offered.angle};
                    nv = 1'b1;
                end
            end
        end
        s_axis_tvalid <= nv;
    end

    // ---------------- monitor ----------------
    int n_readings = 0;
    int hold_left = 0;
    int long_hold = 0;

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        logic    rdy;
        if (!i_rst_n) begin
            rdy = 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.rotation_count   = m_axis_tdata[31:0];
                got.shaft_angle      = m_axis_tdata[43:32];
                got.velocity_cps     = m_axis_tdata[75:44];
                got.electrical_angle = m_axis_tdata[87:76];
                got.velocity_updated = m_axis_tuser;
                if (reading_q.size() == 0) begin
                    report($sformatf("unexpected word %h tuser %b", m_axis_tdata, m_axis_tuser));
                end else begin
                    want = reading_q.pop_front();
                    if (got.rotation_count !== want.rotation_count)
                        report($sformatf("word %0d rotation_count %0d, expected %0d",
                               n_readings, got.rotation_count, want.rotation_count));
                    if (got.shaft_angle !== want.shaft_angle)
                        report($sformatf("word %0d shaft_angle %0d, expected %0d",
                               n_readings, got.shaft_angle, want.shaft_angle));
                    if (got.velocity_cps !== want.velocity_cps)
                        report($sformatf("word %0d velocity_cps %0d, expected %0d",
                               n_readings, got.velocity_cps, want.velocity_cps));
                    if (got.velocity_updated !== want.velocity_updated)
                        report($sformatf("word %0d velocity_updated %b, expected %b",
                               n_readings, got.velocity_updated, want.velocity_updated));
                    if (got.electrical_angle !== want.electrical_angle)
                        report($sformatf("word %0d electrical_angle %0d, expected %0d",
                               n_readings, got.electrical_angle, want.electrical_angle));
                end
                n_readings++;
                hold_left = ((n_readings / 40) % 4 == 3) ? 0 : $urandom_range(0, 11);
                // long back-pressure so the input side fills and stalls
                if (n_readings == 300 || n_readings == 1100) long_hold = 400;
            end
            if (long_hold > 0) begin
                long_hold--;
                rdy = 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
        end
        m_axis_tready <= rdy;
    end

    // ---------------- stimulus ----------------
    task automatic push_sample(input int angle, input logic [31:0] ts);
        samples_q.push_back('{angle[11:0], ts, 1'b0});
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_MIN_ELAPSED: regs.min_elapsed = data;
            REG_POLE_PAIRS:  regs.pp_count    = data[6:0];
            REG_ZERO_OFFSET: regs.zero_offset = data[11:0];
            REG_REVERSE:     regs.reverse     = data[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input t_settings s);
        write_reg(REG_MIN_ELAPSED, s.min_elapsed);
        write_reg(REG_POLE_PAIRS, 16'(s.pp_count));
        write_reg(REG_ZERO_OFFSET, 16'(s.zero_offset));
        write_reg(REG_REVERSE, 16'(s.reverse));
    endtask

    task automatic wait_idle();
        while (samples_q.size() != 0 || reading_q.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        // let a recomputing word finish its way through the block
        repeat (60) @(posedge i_clk);
    endtask

    // runs of plausible motion with random content, plus some noise
    task automatic queue_motion(input int count);
        int          ang;
        int          step;
        int          speed;
        int          run_left;
        int          roll;
        int          mn;
        logic [31:0] ts;
        t_sample     s;
        ang = $urandom_range(0, 4095);
        ts = $urandom();
        run_left = 0;
        speed = 0;
        mn = (regs.min_elapsed == 0) ? 1 : int'(regs.min_elapsed);
        for (int i = 0; i < count; i++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(5, 40);
                speed = $urandom_range(0, 2);
            end
            run_left--;
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                ang = $urandom_range(0, 4095);
                ts = $urandom();
            end else begin
                case (speed)
                    0: step = $urandom_range(0, 20) - 10;
                    1: step = $urandom_range(0, 600) - 300;
                    default: step = $urandom_range(0, 3000) - 1500;
                endcase
                ang = (ang + step + 8192) % 4096;
                if (roll < 12)
                    ts = ts - $urandom_range(1, 1000);
                else if (roll < 30)
                    ts = ts + $urandom_range(0, mn - 1);
                else
                    ts = ts + $urandom_range(mn, 3 * mn + 10);
            end
            s = '{ang[11:0], ts, (i == count / 2)};
            samples_q.push_back(s);
        end
    endtask

    initial begin
        t_settings plan[6];
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: priming, wrap thresholds, too soon, time backwards, timestamp wrap
        push_sample(0, 32'd1000);
        push_sample(4095, 32'd1050);
        push_sample(0, 32'd1100);
        push_sample(3277, 32'd1200);
        push_sample(0, 32'd1300);
        push_sample(3276, 32'd1400);
        push_sample(0, 32'd1500);
        push_sample(100, 32'd500);
        push_sample(200, 32'd600);
        push_sample(2048, 32'hFFFF_FFF0);
        push_sample(2100, 32'h0000_0050);
        push_sample(2200, 32'h0000_0070);
        wait_idle();

        // fastest updates: velocity saturates both ways
        apply_settings('{16'd1, 7'd64, 12'd4095, 1'b1});
        push_sample(0, 32'd5000);
        push_sample(4000, 32'd5001);
        push_sample(1000, 32'd5002);
        push_sample(4000, 32'd5003);
        wait_idle();

        // zero registers: minimum acts as one, no pole pairs
        apply_settings('{16'd0, 7'd0, 12'd1, 1'b0});
        push_sample(5, 32'd10000);
        push_sample(6, 32'd10000);
        push_sample(7, 32'd10001);
        wait_idle();

        // slowest updates and the longest forward elapsed time
        apply_settings('{16'hFFFF, 7'h7F, 12'd2048, 1'b1});
        push_sample(1234, 32'd20000);
        push_sample(1300, 32'd20000 + 32'd65534);
        push_sample(1400, 32'd20000 + 32'd65535 + 32'd65534);
        push_sample(3000, 32'd20000 + 32'd65535 + 32'd65534 + 32'h7FFF_FFFF);
        wait_idle();

        plan[0] = '{16'd100, 7'd7, 12'd0, 1'b0};
        plan[1] = '{16'd1, 7'd1, 12'd0, 1'b0};
        plan[2] = '{16'd65535, 7'd64, 12'd4095, 1'b1};
        plan[3] = '{16'($urandom_range(1, 300)), 7'($urandom_range(1, 64)),
                    12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1))};
        plan[4] = '{16'($urandom_range(1, 20)), 7'($urandom_range(1, 64)),
                    12'($urandom_range(0, 4095)), 1'b1};
        plan[5] = '{16'($urandom_range(1, 65535)), 7'($urandom_range(1, 64)),
                    12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1))};
        foreach (plan[p]) begin
            apply_settings(plan[p]);
            queue_motion(250);
            wait_idle();
        end

        if (reading_q.size() != 0)
            report($sformatf("%0d readings never arrived", reading_q.size()));
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
